/* rtl/ctsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsc_pkg: shared types and constants of the clock time-set controller
// Holds the poll and result payloads, the controller state and digit helpers.
// ----------------------------------------------------------------------------
package ctsc_pkg;

	typedef enum logic [1:0] {
		MODE_SHOW  = 2'd0,
		MODE_SET   = 2'd1,
		MODE_SLEEP = 2'd2
	} mode_t;

	localparam logic [7:0] IDLE_LIMIT_RESET = 8'd60;
	localparam logic [1:0] LAST_POSITION    = 2'd3;
	localparam logic [3:0] DIGIT_MAX        = 4'd9;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic       select_pressed;
		logic       left_pressed;
		logic       right_pressed;
		logic [4:0] rtc_hours;
		logic [5:0] rtc_minutes;
		logic [5:0] rtc_seconds;
	} poll_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] digit_hours_tens;
		logic [3:0] digit_hours_ones;
		logic [3:0] digit_minutes_tens;
		logic [3:0] digit_minutes_ones;
		logic [1:0] selected_position;
		logic       blank_selected;
		logic       colon_on;
		logic       set_strobe;
		logic [6:0] set_hours;
		logic [6:0] set_minutes;
	} result_t;

	typedef struct packed {
		mode_t            mode;
		logic             press_latched;
		digit_t [3:0]     digits;
		logic [1:0]       edit_position;
		logic [7:0]       idle_count;
		logic             colon_level;
	} ctl_state_t;

	// Tens digit of a value below 64.
	function automatic digit_t tens_of(input logic [5:0] val);
		digit_t t;
		if (val >= 6'd60) begin
			t = 4'd6;
		end else if (val >= 6'd50) begin
			t = 4'd5;
		end else if (val >= 6'd40) begin
			t = 4'd4;
		end else if (val >= 6'd30) begin
			t = 4'd3;
		end else if (val >= 6'd20) begin
			t = 4'd2;
		end else if (val >= 6'd10) begin
			t = 4'd1;
		end else begin
			t = 4'd0;
		end
		return t;
	endfunction

	function automatic digit_t ones_of(input logic [5:0] val);
		logic [6:0] prod;
		logic [5:0] rem;
		prod = {3'd0, tens_of(val)} * 7'd10;
		rem  = val - prod[5:0];
		return rem[3:0];
	endfunction

	function automatic logic [6:0] pair_value(input digit_t hi, input digit_t lo);
		logic [7:0] sum;
		sum = {4'd0, hi} * 8'd10 + {4'd0, lo};
		return sum[6:0];
	endfunction

endpackage

/* rtl/ctsc_poll_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsc_poll_if: poll channel of the clock time-set controller
// Valid/ready channel that carries one button and clock poll per transfer.
// ----------------------------------------------------------------------------
interface ctsc_poll_if;
	import ctsc_pkg::*;

	logic  valid;
	logic  ready;
	poll_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/ctsc_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsc_result_if: result channel of the clock time-set controller
// Valid/ready channel that carries one display and set result per transfer.
// ----------------------------------------------------------------------------
interface ctsc_result_if;
	import ctsc_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/ctsc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsc_step: next-state and result logic of the clock time-set controller
// Applies one poll to the controller state and forms the matching result.
// ----------------------------------------------------------------------------
module ctsc_step (
	input  ctsc_pkg::poll_t      poll,
	input  ctsc_pkg::ctl_state_t cur,
	input  logic [7:0]           idle_limit,
	output ctsc_pkg::ctl_state_t nxt,
	output ctsc_pkg::result_t    res
);
	import ctsc_pkg::*;

	logic       odd;
	logic       strobe;
	logic [6:0] set_h;
	logic [6:0] set_m;
	digit_t     cur_digit;
	digit_t     stepped;

	assign odd       = poll.rtc_seconds[0];
	assign cur_digit = cur.digits[cur.edit_position];

	always_comb begin
		if (poll.right_pressed && !poll.left_pressed) begin
			stepped = (cur_digit >= DIGIT_MAX) ? 4'd0 : cur_digit + 4'd1;
		end else begin
			stepped = (cur_digit == 4'd0) ? DIGIT_MAX : cur_digit - 4'd1;
		end
	end

	always_comb begin
		nxt    = cur;
		strobe = 1'b0;
		set_h  = 7'd0;
		set_m  = 7'd0;

		if (poll.select_pressed) begin
			nxt.idle_count = 8'd0;
			if (!cur.press_latched) begin
				nxt.press_latched = 1'b1;
				case (cur.mode)
					MODE_SLEEP: begin
						nxt.mode = MODE_SHOW;
					end
					MODE_SHOW: begin
						nxt.digits        = '0;
						nxt.edit_position = 2'd0;
						nxt.mode          = MODE_SET;
					end
					default: begin
						if (cur.edit_position != LAST_POSITION) begin
							nxt.edit_position = cur.edit_position + 2'd1;
						end else begin
							strobe   = 1'b1;
							set_h    = pair_value(cur.digits[0], cur.digits[1]);
							set_m    = pair_value(cur.digits[2], cur.digits[3]);
							nxt.mode = MODE_SHOW;
						end
					end
				endcase
			end
		end else if (poll.left_pressed || poll.right_pressed) begin
			nxt.idle_count = 8'd0;
			if (cur.mode == MODE_SLEEP) begin
				nxt.mode = MODE_SHOW;
			end else if (!cur.press_latched) begin
				nxt.press_latched                  = 1'b1;
				nxt.digits[cur.edit_position]      = stepped;
			end
		end else begin
			nxt.press_latched = 1'b0;
		end

		if (nxt.mode == MODE_SHOW) begin
			nxt.digits[0] = tens_of({1'b0, poll.rtc_hours});
			nxt.digits[1] = ones_of({1'b0, poll.rtc_hours});
			nxt.digits[2] = tens_of(poll.rtc_minutes);
			nxt.digits[3] = ones_of(poll.rtc_minutes);
			if (odd != cur.colon_level) begin
				nxt.colon_level = odd;
				if (nxt.idle_count < idle_limit) begin
					nxt.idle_count = nxt.idle_count + 8'd1;
				end
				if (nxt.idle_count >= idle_limit) begin
					nxt.mode = MODE_SLEEP;
				end
			end
		end
	end

	always_comb begin
		res.mode               = nxt.mode;
		res.digit_hours_tens   = nxt.digits[0];
		res.digit_hours_ones   = nxt.digits[1];
		res.digit_minutes_tens = nxt.digits[2];
		res.digit_minutes_ones = nxt.digits[3];
		res.selected_position  = nxt.edit_position;
		res.blank_selected     = (nxt.mode == MODE_SET) && odd;
		res.colon_on           = nxt.colon_level;
		res.set_strobe         = strobe;
		res.set_hours          = set_h;
		res.set_minutes        = set_m;
	end

endmodule

/* rtl/clock_time_set_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_time_set_controller: menu control for a four-digit clock
// Turns button and clock polls into display digits, mode and time-set strobes.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the poll channel carries the three button levels and the
// current clock time. Every poll gives exactly one transfer on the result
// channel with the mode, the four digits, the edit position, blanking, the
// colon level and, on the poll that commits a time, the set strobe with the
// hours and minutes to write.
// A taken poll is registered in poll_s1, and its result is registered in the
// output register when the state advances. One poll is taken per cycle while
// the receiver keeps up. A finished result waits in the output register while
// the next poll is taken; when the receiver stalls with both registers full,
// the poll channel drops ready until the result is taken.
// Reset puts the block in show mode with all digits, counters and latches
// at zero and the idle limit at 60. The user must write the idle limit through
// cfg_we and cfg_wdata while no poll is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module clock_time_set_controller (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	ctsc_poll_if.sink    poll,
	ctsc_result_if.source result
);
	import ctsc_pkg::*;

	poll_t      poll_s1;
	logic       valid_s1;
	result_t    result_q;
	logic       result_valid_q;
	ctl_state_t state_q;
	ctl_state_t state_nxt;
	result_t    result_nxt;
	logic [7:0] idle_limit_q;
	logic       advance;

	assign advance    = valid_s1 && (!result_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;

	ctsc_step u_step (
		.poll       (poll_s1),
		.cur        (state_q),
		.idle_limit (idle_limit_q),
		.nxt        (state_nxt),
		.res        (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_LIMIT_RESET;
		end else if (cfg_we) begin
			idle_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			poll_s1 <= poll.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_SHOW, press_latched: 1'b0, digits: '0,
				edit_position: 2'd0, idle_count: 8'd0, colon_level: 1'b0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign result.valid = result_valid_q;
	assign result.data  = result_q;

endmodule

/* tb/clock_time_set_controller_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_time_set_controller_test: self-checking bench of the time-set menu
// Polls with button levels and clock readings go in through the poll channel
// with random gaps. A tracker class predicts every display result, and each
// result transfer is compared field by field. The run steps through several
// idle limits, from zero to the largest, and stalls the result side at times.
// ----------------------------------------------------------------------------
module clock_time_set_controller_test;
	import ctsc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	class menu_tracker;
		mode_t      mode;
		logic       latched;
		logic [3:0] digits [4];
		logic [1:0] edit_pos;
		logic [7:0] idle_cnt;
		logic       colon;
		logic [7:0] idle_limit;
		result_t    expected_results [$];
		int         errors;
		int         commits;
		int         sleeps;
		int         checked;

		function new();
			mode       = MODE_SHOW;
			latched    = 1'b0;
			foreach (digits[i]) digits[i] = '0;
			edit_pos   = '0;
			idle_cnt   = '0;
			colon      = 1'b0;
			idle_limit = IDLE_LIMIT_RESET;
			errors     = 0;
			commits    = 0;
			sleeps     = 0;
			checked    = 0;
		endfunction

		function logic [3:0] step_digit(logic [3:0] d, bit up);
			if (up) begin
				return (d >= 4'd9) ? 4'd0 : d + 4'd1;
			end
			return (d == 4'd0) ? 4'd9 : d - 4'd1;
		endfunction

		function void note_poll(poll_t p);
			result_t    r;
			logic [1:0] pos;
			mode_t      was;
			r   = '0;
			pos = edit_pos;
			was = mode;
			if (p.select_pressed) begin
				idle_cnt = '0;
				if (!latched) begin
					latched = 1'b1;
					case (mode)
						MODE_SLEEP: mode = MODE_SHOW;
						MODE_SHOW: begin
							foreach (digits[i]) digits[i] = '0;
							edit_pos = '0;
							mode     = MODE_SET;
						end
						default: begin
							if (pos < LAST_POSITION) begin
								edit_pos = pos + 2'd1;
							end else begin
								r.set_strobe  = 1'b1;
								r.set_hours   = 7'(digits[0] * 10 + digits[1]);
								r.set_minutes = 7'(digits[2] * 10 + digits[3]);
								mode          = MODE_SHOW;
								commits++;
							end
						end
					endcase
				end
			end else if (p.left_pressed || p.right_pressed) begin
				idle_cnt = '0;
				if (mode == MODE_SLEEP) begin
					mode = MODE_SHOW;
				end else if (!latched) begin
					latched     = 1'b1;
					digits[pos] = step_digit(digits[pos], !p.left_pressed);
				end
			end else begin
				latched = 1'b0;
			end

			if (mode == MODE_SHOW) begin
				digits[0] = 4'(int'(p.rtc_hours) / 10);
				digits[1] = 4'(int'(p.rtc_hours) % 10);
				digits[2] = 4'(int'(p.rtc_minutes) / 10);
				digits[3] = 4'(int'(p.rtc_minutes) % 10);
				if (p.rtc_seconds[0] != colon) begin
					colon = p.rtc_seconds[0];
					if (idle_cnt < idle_limit) begin
						idle_cnt++;
					end
					if (idle_cnt >= idle_limit) begin
						mode = MODE_SLEEP;
					end
				end
			end
			if (mode == MODE_SLEEP && was != MODE_SLEEP) begin
				sleeps++;
			end

			r.mode               = mode;
			r.digit_hours_tens   = digits[0];
			r.digit_hours_ones   = digits[1];
			r.digit_minutes_tens = digits[2];
			r.digit_minutes_ones = digits[3];
			r.selected_position  = edit_pos;
			r.blank_selected     = (mode == MODE_SET) && p.rtc_seconds[0];
			r.colon_on           = colon;
			expected_results.push_back(r);
		endfunction

		function void compare(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_display(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$error("result transfer with no poll waiting for it");
				errors++;
				return;
			end
			want = expected_results.pop_front();
			checked++;
			compare("mode", want.mode, got.mode);
			compare("digit_hours_tens", want.digit_hours_tens, got.digit_hours_tens);
			compare("digit_hours_ones", want.digit_hours_ones, got.digit_hours_ones);
			compare("digit_minutes_tens", want.digit_minutes_tens, got.digit_minutes_tens);
			compare("digit_minutes_ones", want.digit_minutes_ones, got.digit_minutes_ones);
			compare("selected_position", want.selected_position, got.selected_position);
			compare("blank_selected", want.blank_selected, got.blank_selected);
			compare("colon_on", want.colon_on, got.colon_on);
			compare("set_strobe", want.set_strobe, got.set_strobe);
			compare("set_hours", want.set_hours, got.set_hours);
			compare("set_minutes", want.set_minutes, got.set_minutes);
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [7:0]    cfg_wdata;
	ctsc_poll_if   poll_ch ();
	ctsc_result_if res_ch ();

	menu_tracker tracker = new();
	poll_t       queued_polls [$];
	int          polls_queued;
	int          polls_taken;
	int          limits_written;
	bit          hold_req;
	bit          no_gaps;

	clock_time_set_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.poll      (poll_ch),
		.result    (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		poll_ch.valid <= 1'b0;
		poll_ch.data  <= '0;
		forever begin
			@(posedge clk);
			if (poll_ch.valid && poll_ch.ready) begin
				tracker.note_poll(poll_ch.data);
				polls_taken++;
			end
			if (!poll_ch.valid || poll_ch.ready) begin
				if (arst_n && queued_polls.size() != 0 &&
				    (no_gaps || $urandom_range(99) >= 34)) begin
					poll_ch.valid <= 1'b1;
					poll_ch.data  <= queued_polls.pop_front();
				end else begin
					poll_ch.valid <= 1'b0;
				end
			end
		end
	end

	initial begin
		int hold_left;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				tracker.check_display(res_ch.data);
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= no_gaps || ($urandom_range(99) >= 34);
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	function void push_exact(bit s, bit l, bit r, logic [4:0] h, logic [5:0] m,
	                         logic [5:0] sec);
		poll_t p;
		p.select_pressed = s;
		p.left_pressed   = l;
		p.right_pressed  = r;
		p.rtc_hours      = h;
		p.rtc_minutes    = m;
		p.rtc_seconds    = sec;
		queued_polls.push_back(p);
		polls_queued++;
	endfunction

	function void push_poll(bit s, bit l, bit r, int parity = -1);
		logic [5:0] sec;
		sec = 6'($urandom_range(63));
		if (parity >= 0) begin
			sec[0] = parity[0];
		end
		push_exact(s, l, r, 5'($urandom_range(31)), 6'($urandom_range(63)), sec);
	endfunction

	function void push_idle_run(int n);
		int start;
		start = $urandom_range(1);
		for (int i = 0; i < n; i++) begin
			push_poll(1'b0, 1'b0, 1'b0, (start + i) % 2);
		end
	endfunction

	function void push_set_sequence();
		int p;
		int kind;
		p = $urandom_range(1);
		// Wake with a side button, then enter set mode without a colon change.
		push_poll(1'b0, 1'b1, 1'b0, p);
		push_poll(1'b0, 1'b0, 1'b0, p);
		push_poll(1'b1, 1'b0, 1'b0, p);
		push_poll(1'b0, 1'b0, 1'b0, p);
		for (int d = 0; d < 4; d++) begin
			repeat ($urandom_range(6)) begin
				kind = $urandom_range(2);
				push_poll(1'b0, kind != 1, kind != 0);
				if ($urandom_range(3) == 0) begin
					push_poll(1'b0, kind != 1, kind != 0);
				end
				push_poll(1'b0, 1'b0, 1'b0);
			end
			push_poll(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
			push_poll(1'b0, 1'b0, 1'b0);
		end
	endfunction

	task automatic settle();
		while (polls_taken != polls_queued || tracker.expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.idle_limit = value;
		limits_written++;
	endtask

	task automatic run_directed();
		push_exact(0, 0, 0, 5'd0, 6'd0, 6'd0);
		push_exact(0, 0, 0, 5'd31, 6'd63, 6'd63);
		push_exact(0, 1, 0, 5'd12, 6'd34, 6'd63);
		push_exact(0, 0, 0, 5'd12, 6'd34, 6'd62);
		push_exact(0, 0, 1, 5'd23, 6'd59, 6'd62);
		push_exact(0, 0, 0, 5'd23, 6'd59, 6'd61);
		push_exact(1, 0, 0, 5'd9, 6'd9, 6'd61);
		push_exact(1, 0, 0, 5'd9, 6'd9, 6'd60);
		push_exact(0, 0, 0, 5'd9, 6'd9, 6'd59);
		push_exact(0, 1, 0, 5'd9, 6'd9, 6'd58);
		push_exact(0, 0, 0, 5'd9, 6'd9, 6'd57);
		push_exact(1, 1, 1, 5'd9, 6'd9, 6'd56);
		push_exact(0, 0, 0, 5'd9, 6'd9, 6'd55);
		push_exact(0, 0, 1, 5'd9, 6'd9, 6'd54);
		push_exact(0, 0, 0, 5'd9, 6'd9, 6'd53);
		push_exact(1, 0, 0, 5'd9, 6'd9, 6'd52);
		push_exact(0, 0, 0, 5'd9, 6'd9, 6'd51);
		push_exact(1, 0, 0, 5'd9, 6'd9, 6'd50);
		push_exact(0, 0, 0, 5'd9, 6'd9, 6'd49);
		push_exact(1, 0, 0, 5'd31, 6'd63, 6'd40);
		settle();
		write_limit(8'd0);
		push_exact(0, 0, 0, 5'd0, 6'd0, 6'd1);
		push_exact(0, 1, 0, 5'd0, 6'd0, 6'd1);
		push_exact(0, 0, 0, 5'd0, 6'd0, 6'd2);
		push_exact(1, 0, 0, 5'd0, 6'd0, 6'd2);
		push_exact(0, 0, 0, 5'd0, 6'd0, 6'd3);
	endtask

	task automatic run_phase(input logic [7:0] limit, input int n_items, input bit long_idle,
	                         input bit hold, input bit gapless);
		int target;
		int pick;
		settle();
		write_limit(limit);
		no_gaps = gapless;
		if (hold) begin
			hold_req = 1'b1;
		end
		target = polls_queued + n_items;
		if (long_idle) begin
			push_idle_run(260);
		end
		while (polls_queued < target) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				push_set_sequence();
			end else if (pick < 75) begin
				push_idle_run($urandom_range(1, 30));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					push_poll(1'($urandom_range(1)), 1'($urandom_range(1)),
					          1'($urandom_range(1)));
				end
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_phase(8'd255, 60, 1'b1, 1'b0, 1'b0);
		run_phase(8'd1, 60, 1'b0, 1'b1, 1'b0);
		run_phase(8'd0, 60, 1'b0, 1'b0, 1'b0);
		run_phase(8'($urandom_range(2, 8)), 60, 1'b0, 1'b0, 1'b1);
		run_phase(8'($urandom_range(1, 255)), 60, 1'b0, 1'b0, 1'b0);
		run_phase(8'd60, 60, 1'b0, 1'b1, 1'b0);
		run_phase(8'd3, 60, 1'b0, 1'b0, 1'b0);
		run_phase(8'($urandom_range(1, 20)), 60, 1'b0, 1'b0, 1'b0);
		settle();
		$display("Summary: %0d results checked over %0d idle limit writes.",
		         tracker.checked, limits_written);
		$display("Summary: %0d time commits and %0d entries into sleep were seen.",
		         tracker.commits, tracker.sleeps);
		if (tracker.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
